>>> rtl/tpsc_pkg.sv
// shared types, codes and reset values of the two-page smooth scroll controller
package tpsc_pkg;

  // default scan offset at which a text line starts scrolling
  localparam int unsigned TOP_SCAN_DEFAULT = 13;

  localparam int unsigned ROW_W  = 6;
  localparam int unsigned SCAN_W = 4;
  localparam int unsigned ADDR_W = 17;
  localparam int unsigned HW_W   = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned RES_SLOTS  = 3;
  localparam int unsigned CNT_W      = 2;

  // request function codes
  localparam logic [1:0] FUNC_UP   = 2'd0;
  localparam logic [1:0] FUNC_DOWN = 2'd1;
  localparam logic [1:0] FUNC_STOP = 2'd2;

  // result command codes
  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_SET_TOP = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCROLLED_LINES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_LINES    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_LIMIT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_BYTES     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS   = 3'd4;

  localparam logic [4:0]        SCROLLED_LINES_RST = 5'd16;
  localparam logic [5:0]        TOTAL_LINES_RST    = 6'd34;
  localparam logic [5:0]        TOP_LIMIT_RST      = 6'd18;
  localparam logic [9:0]        LINE_BYTES_RST     = 10'd144;
  localparam logic [ADDR_W-1:0] BASE_ADDRESS_RST   = '0;

  typedef struct packed {
    logic [4:0]        scrolled_lines;
    logic [5:0]        total_lines;
    logic [5:0]        top_limit;
    logic [9:0]        line_bytes;
    logic [ADDR_W-1:0] base_address;
  } cfg_t;

  typedef struct packed {
    logic [ROW_W-1:0]  top_line;
    logic [SCAN_W-1:0] scan_offset;
    logic              scrolling_up;
    logic              scrolling_down;
    logic [ADDR_W-1:0] prev_top_addr;
  } state_t;

  typedef struct packed {
    logic              command;
    logic [ROW_W-1:0]  row;
    logic [SCAN_W-1:0] scan;
    logic [HW_W-1:0]   halfword_address;
    logic              address_changed;
    logic              last;
  } res_t;

endpackage

>>> rtl/tpsc_step.sv
// per-request scroll logic: next state and the list of up to three commands
module tpsc_step #(
  parameter int unsigned TOP_SCAN = tpsc_pkg::TOP_SCAN_DEFAULT
) (
  input  tpsc_pkg::cfg_t                   cfg,
  input  tpsc_pkg::state_t                 st,
  input  logic [1:0]                       func,
  input  logic                             line_ready,
  output tpsc_pkg::state_t                 st_nxt,
  output tpsc_pkg::res_t                   res [tpsc_pkg::RES_SLOTS],
  output logic [tpsc_pkg::CNT_W-1:0]       res_cnt
);

  localparam logic [tpsc_pkg::SCAN_W-1:0] TS = TOP_SCAN[tpsc_pkg::SCAN_W-1:0];

  tpsc_pkg::state_t            st_mid;
  logic [tpsc_pkg::ROW_W-1:0]  wr_row [2];
  logic [tpsc_pkg::CNT_W-1:0]  nwr;
  logic                        emit_top;
  logic                        dbl_top;
  logic [6:0]                  dup_sum;
  logic [tpsc_pkg::ADDR_W-1:0] prod;
  logic [tpsc_pkg::ADDR_W-1:0] addr;
  logic                        chg;
  logic [tpsc_pkg::CNT_W-1:0]  slot;

  // unwrapped sum for the duplicate-row range test on scroll down
  assign dup_sum = {1'b0, st.top_line} + {2'b00, cfg.scrolled_lines} + 7'd1;

  always_comb begin
    st_mid    = st;
    wr_row[0] = '0;
    wr_row[1] = '0;
    nwr       = '0;
    emit_top  = 1'b0;
    dbl_top   = 1'b0;
    unique case (func)
      tpsc_pkg::FUNC_UP: begin
        st_mid.scrolling_up   = 1'b1;
        st_mid.scrolling_down = 1'b0;
        if (st.scan_offset == TS) begin
          if (line_ready) begin
            emit_top           = 1'b1;
            st_mid.scan_offset = TS - 4'd1;
            if (st.top_line == cfg.top_limit) begin
              // page swap back to the first page
              wr_row[0]       = {1'b0, cfg.scrolled_lines};
              nwr             = 2'd1;
              st_mid.top_line = '0;
              dbl_top         = 1'b1;
            end else begin
              wr_row[0] = st.top_line + {1'b0, cfg.scrolled_lines};
              wr_row[1] = st.top_line - 6'd2;
              nwr       = (st.top_line >= 6'd2) ? 2'd2 : 2'd1;
            end
          end
        end else if (st.scan_offset == 4'd0) begin
          emit_top           = 1'b1;
          st_mid.top_line    = st.top_line + 6'd1;
          st_mid.scan_offset = TS;
        end else begin
          emit_top           = 1'b1;
          st_mid.scan_offset = st.scan_offset - 4'd1;
        end
      end
      tpsc_pkg::FUNC_DOWN: begin
        st_mid.scrolling_down = 1'b1;
        st_mid.scrolling_up   = 1'b0;
        if (st.scan_offset == TS) begin
          if (line_ready) begin
            emit_top           = 1'b1;
            st_mid.scan_offset = '0;
            if (st.top_line == 6'd0) begin
              // page swap to the second page
              st_mid.top_line = cfg.top_limit - 6'd1;
              wr_row[0]       = cfg.top_limit - 6'd1;
              nwr             = 2'd1;
            end else begin
              st_mid.top_line = st.top_line - 6'd1;
              wr_row[0]       = st.top_line - 6'd1;
              wr_row[1]       = dup_sum[5:0];
              nwr             = (dup_sum < {1'b0, cfg.total_lines}) ? 2'd2 : 2'd1;
            end
          end
        end else begin
          emit_top           = 1'b1;
          st_mid.scan_offset = st.scan_offset + 4'd1;
        end
      end
      tpsc_pkg::FUNC_STOP: begin
        st_mid.scrolling_up   = 1'b0;
        st_mid.scrolling_down = 1'b0;
        if (st.scrolling_down) begin
          emit_top           = 1'b1;
          st_mid.scan_offset = TS;
        end else if (st.scrolling_up) begin
          emit_top           = 1'b1;
          st_mid.top_line    = st.top_line + 6'd1;
          st_mid.scan_offset = TS;
        end
      end
      default: begin
      end
    endcase
  end

  // every set-top of one request uses the new top line
  assign prod = {11'b0, st_mid.top_line} * {7'b0, cfg.line_bytes};
  assign addr = cfg.base_address + prod;
  assign chg  = (addr != st.prev_top_addr);

  always_comb begin
    res_cnt = emit_top ? (nwr + 2'd1 + {1'b0, dbl_top}) : '0;
    for (int i = 0; i < tpsc_pkg::RES_SLOTS; i++) begin
      slot   = i[tpsc_pkg::CNT_W-1:0];
      res[i] = '0;
      if (slot < nwr) begin
        res[i].command = tpsc_pkg::CMD_WRITE;
        res[i].row     = wr_row[i[0]];
      end else if (slot == nwr) begin
        res[i].command          = tpsc_pkg::CMD_SET_TOP;
        res[i].row              = st_mid.top_line;
        res[i].scan             = dbl_top ? TS : st_mid.scan_offset;
        res[i].halfword_address = addr[tpsc_pkg::ADDR_W-1:1];
        res[i].address_changed  = chg;
      end else begin
        // second set-top after a page swap: same address, no change
        res[i].command          = tpsc_pkg::CMD_SET_TOP;
        res[i].row              = st_mid.top_line;
        res[i].scan             = st_mid.scan_offset;
        res[i].halfword_address = addr[tpsc_pkg::ADDR_W-1:1];
        res[i].address_changed  = 1'b0;
      end
      res[i].last = (slot == res_cnt - 2'd1);
    end
  end

  // the state register keeps the newest set-top address
  always_comb begin
    st_nxt               = st_mid;
    st_nxt.prev_top_addr = emit_top ? addr : st.prev_top_addr;
  end

endmodule

>>> rtl/two_page_smooth_scroll_controller.sv
// top level of the two-page smooth scroll controller
//
//  port group  | direction | handshake          | payload
//  in_         | in        | in_valid/in_ready  | func, line_ready
//  out_        | out       | out_valid/out_ready| command, row, scan, halfword_address,
//              |           |                    | address_changed, last
//  cfg_        | in        | cfg_we             | cfg_index, cfg_data
//
// a request is registered, then decoded combinationally into up to three commands
// held in a three-entry result buffer; the first command is valid once the buffer
// has loaded them, which waits while earlier commands are still pending
// the buffer drains one command a cycle while out_ready is high; a new request loads
// as the last command leaves
// requests that give no command produce nothing
// reset is synchronous and clears the scroll state, buffer and config to defaults
module two_page_smooth_scroll_controller #(
  parameter int unsigned TOP_SCAN = tpsc_pkg::TOP_SCAN_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_func,
  input  logic                                in_line_ready,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_command,
  output logic [tpsc_pkg::ROW_W-1:0]          out_row,
  output logic [tpsc_pkg::SCAN_W-1:0]         out_scan,
  output logic [tpsc_pkg::HW_W-1:0]           out_halfword_address,
  output logic                                out_address_changed,
  output logic                                out_last,
  input  logic                                cfg_we,
  input  logic [tpsc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tpsc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam logic [tpsc_pkg::SCAN_W-1:0] TS = TOP_SCAN[tpsc_pkg::SCAN_W-1:0];

  tpsc_pkg::cfg_t             cfg_r;
  tpsc_pkg::state_t           st_r;
  tpsc_pkg::state_t           st_nxt;
  tpsc_pkg::res_t             res_nxt [tpsc_pkg::RES_SLOTS];
  tpsc_pkg::res_t             res_r   [tpsc_pkg::RES_SLOTS];
  logic [tpsc_pkg::CNT_W-1:0] res_cnt_nxt;
  logic [tpsc_pkg::CNT_W-1:0] cnt_r;
  logic                       req_valid_r;
  logic [1:0]                 req_func_r;
  logic                       req_line_ready_r;
  logic                       out_fire;
  logic                       load;

  assign out_fire = out_valid && out_ready;
  assign load     = req_valid_r && ((cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_fire));
  assign in_ready = !req_valid_r || load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scrolled_lines <= tpsc_pkg::SCROLLED_LINES_RST;
      cfg_r.total_lines    <= tpsc_pkg::TOTAL_LINES_RST;
      cfg_r.top_limit      <= tpsc_pkg::TOP_LIMIT_RST;
      cfg_r.line_bytes     <= tpsc_pkg::LINE_BYTES_RST;
      cfg_r.base_address   <= tpsc_pkg::BASE_ADDRESS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tpsc_pkg::CFG_SCROLLED_LINES: cfg_r.scrolled_lines <= cfg_data[4:0];
        tpsc_pkg::CFG_TOTAL_LINES:    cfg_r.total_lines    <= cfg_data[5:0];
        tpsc_pkg::CFG_TOP_LIMIT:      cfg_r.top_limit      <= cfg_data[5:0];
        tpsc_pkg::CFG_LINE_BYTES:     cfg_r.line_bytes     <= cfg_data[9:0];
        tpsc_pkg::CFG_BASE_ADDRESS:   cfg_r.base_address   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      req_valid_r <= 1'b1;
    end else if (load) begin
      req_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_func_r       <= in_func;
      req_line_ready_r <= in_line_ready;
    end
  end

  tpsc_step #(
    .TOP_SCAN (TOP_SCAN)
  ) u_step (
    .cfg        (cfg_r),
    .st         (st_r),
    .func       (req_func_r),
    .line_ready (req_line_ready_r),
    .st_nxt     (st_nxt),
    .res        (res_nxt),
    .res_cnt    (res_cnt_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (load) begin
      st_r <= st_nxt;
    end
  end

  // result buffer, entry 0 drives the output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= res_cnt_nxt;
    end else if (out_fire) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end else if (out_fire) begin
      res_r[0] <= res_r[1];
      res_r[1] <= res_r[2];
    end
  end

  assign out_valid            = (cnt_r != 2'd0);
  assign out_command          = res_r[0].command;
  assign out_row              = res_r[0].row;
  assign out_scan             = res_r[0].scan;
  assign out_halfword_address = res_r[0].halfword_address;
  assign out_address_changed  = res_r[0].address_changed;
  assign out_last             = res_r[0].last;

  a_last_is_final : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> cnt_r == 2'd1)
    else $error("last flag on a command that is not the final one");

  a_more_pending : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> cnt_r != 2'd1)
    else $error("final buffered command lacks last flag");

  a_scan_range : assert property (@(posedge clk) disable iff (!rst_n)
    st_r.scan_offset <= TS)
    else $error("scan offset beyond top scan");

  a_addr_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !load |=> $stable(st_r.prev_top_addr))
    else $error("top address changed without a request");

  a_no_load_busy : assert property (@(posedge clk) disable iff (!rst_n)
    load |-> cnt_r == 2'd0 || (cnt_r == 2'd1 && out_fire))
    else $error("buffer overwritten with commands pending");

endmodule

>>> bench/two_page_smooth_scroll_controller_tb.sv
// testbench for the two-page smooth scroll controller: predicted commands checked in order
`timescale 1ns / 1ps

module two_page_smooth_scroll_controller_tb;

  localparam int unsigned ROW_W      = tpsc_pkg::ROW_W;
  localparam int unsigned SCAN_W     = tpsc_pkg::SCAN_W;
  localparam int unsigned ADDR_W     = tpsc_pkg::ADDR_W;
  localparam int unsigned HW_W       = tpsc_pkg::HW_W;
  localparam int unsigned CFG_IDX_W  = tpsc_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W = tpsc_pkg::CFG_DATA_W;

  localparam logic [SCAN_W-1:0] SCAN_TOP    = SCAN_W'(tpsc_pkg::TOP_SCAN_DEFAULT);
  localparam logic [1:0]        FUNC_UNUSED = 2'd3;
  localparam int unsigned       STALL_LIMIT = 1000;
  localparam int unsigned       SETTLE_CYCLES = 4;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [1:0]            in_func;
  logic                  in_line_ready;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_command;
  logic [ROW_W-1:0]      out_row;
  logic [SCAN_W-1:0]     out_scan;
  logic [HW_W-1:0]       out_halfword_address;
  logic                  out_address_changed;
  logic                  out_last;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // predicted configuration and scroll state
  logic [4:0]        exp_scrolled_lines = tpsc_pkg::SCROLLED_LINES_RST;
  logic [5:0]        exp_total_lines    = tpsc_pkg::TOTAL_LINES_RST;
  logic [5:0]        exp_top_limit      = tpsc_pkg::TOP_LIMIT_RST;
  logic [9:0]        exp_line_bytes     = tpsc_pkg::LINE_BYTES_RST;
  logic [ADDR_W-1:0] exp_base_address   = tpsc_pkg::BASE_ADDRESS_RST;
  logic [ROW_W-1:0]  top_row   = '0;
  logic [SCAN_W-1:0] scan_pos  = '0;
  logic              going_up   = 1'b0;
  logic              going_down = 1'b0;
  logic [ADDR_W-1:0] last_top_addr = '0;

  tpsc_pkg::res_t step_cmds[$];
  tpsc_pkg::res_t expected_cmds[$];

  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit          in_gaps_on = 1'b1;
  bit          out_stalls_on = 1'b1;

  two_page_smooth_scroll_controller dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_func              (in_func),
    .in_line_ready        (in_line_ready),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_command          (out_command),
    .out_row              (out_row),
    .out_scan             (out_scan),
    .out_halfword_address (out_halfword_address),
    .out_address_changed  (out_address_changed),
    .out_last             (out_last),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------- prediction

  task automatic add_line_write(input logic [ROW_W-1:0] row);
    tpsc_pkg::res_t r;
    r = '0;
    r.command = tpsc_pkg::CMD_WRITE;
    r.row = row;
    step_cmds.push_back(r);
  endtask

  task automatic add_set_top(input logic [ROW_W-1:0] row, input logic [SCAN_W-1:0] scan);
    logic [ADDR_W-1:0] addr;
    tpsc_pkg::res_t r;
    // byte address wraps at 17 bits
    addr = exp_base_address + ADDR_W'(row) * ADDR_W'(exp_line_bytes);
    r = '0;
    r.command = tpsc_pkg::CMD_SET_TOP;
    r.row = row;
    r.scan = scan;
    r.halfword_address = addr[ADDR_W-1:1];
    r.address_changed = (addr != last_top_addr);
    last_top_addr = addr;
    step_cmds.push_back(r);
  endtask

  task automatic scroll_up_tick(input logic line_ready);
    if (scan_pos == SCAN_TOP) begin
      if (line_ready) begin
        if (top_row == exp_top_limit) begin
          // page swap back to the first page
          add_line_write(ROW_W'(exp_scrolled_lines));
          top_row = '0;
          scan_pos = SCAN_TOP;
          add_set_top(top_row, scan_pos);
        end else begin
          add_line_write(top_row + ROW_W'(exp_scrolled_lines));
          if (top_row >= 2) add_line_write(top_row - ROW_W'(2));
        end
        scan_pos = scan_pos - 1'b1;
        add_set_top(top_row, scan_pos);
      end
    end else if (scan_pos == '0) begin
      top_row = top_row + 1'b1;
      scan_pos = SCAN_TOP;
      add_set_top(top_row, scan_pos);
    end else begin
      scan_pos = scan_pos - 1'b1;
      add_set_top(top_row, scan_pos);
    end
  endtask

  task automatic scroll_down_tick(input logic line_ready);
    if (scan_pos == SCAN_TOP) begin
      if (line_ready) begin
        if (top_row == '0) begin
          top_row = exp_top_limit - 1'b1;
          add_line_write(top_row);
        end else begin
          add_line_write(top_row - 1'b1);
          // duplicate row range test uses the unwrapped sum
          if (int'(top_row) + int'(exp_scrolled_lines) + 1 < int'(exp_total_lines))
            add_line_write(top_row + ROW_W'(exp_scrolled_lines) + 1'b1);
          top_row = top_row - 1'b1;
        end
        scan_pos = '0;
        add_set_top(top_row, scan_pos);
      end
    end else begin
      scan_pos = scan_pos + 1'b1;
      add_set_top(top_row, scan_pos);
    end
  endtask

  task automatic predict_scroll(input logic [1:0] func, input logic line_ready);
    tpsc_pkg::res_t r;
    step_cmds.delete();
    case (func)
      tpsc_pkg::FUNC_UP: begin
        going_up = 1'b1;
        going_down = 1'b0;
        scroll_up_tick(line_ready);
      end
      tpsc_pkg::FUNC_DOWN: begin
        going_down = 1'b1;
        going_up = 1'b0;
        scroll_down_tick(line_ready);
      end
      tpsc_pkg::FUNC_STOP: begin
        if (going_down) begin
          scan_pos = SCAN_TOP;
          add_set_top(top_row, scan_pos);
        end else if (going_up) begin
          top_row = top_row + 1'b1;
          scan_pos = SCAN_TOP;
          add_set_top(top_row, scan_pos);
        end
        going_up = 1'b0;
        going_down = 1'b0;
      end
      default: begin
      end
    endcase
    if (step_cmds.size() > 0) step_cmds[step_cmds.size() - 1].last = 1'b1;
    while (step_cmds.size() > 0) begin
      r = step_cmds.pop_front();
      expected_cmds.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------- driving

  // called and returns at a falling edge; valid stays high for a back-to-back request
  task automatic send_request(input logic [1:0] func, input logic line_ready);
    int unsigned gap;
    gap = in_gaps_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_func = func;
    in_line_ready = line_ready;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_scroll(func, line_ready);
    @(negedge clk);
  endtask

  task automatic wait_for_idle();
    in_valid = 1'b0;
    while (expected_cmds.size() != 0) @(negedge clk);
    // requests without commands may still be in flight
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      tpsc_pkg::CFG_SCROLLED_LINES: exp_scrolled_lines = value[4:0];
      tpsc_pkg::CFG_TOTAL_LINES:    exp_total_lines = value[5:0];
      tpsc_pkg::CFG_TOP_LIMIT:      exp_top_limit = value[5:0];
      tpsc_pkg::CFG_LINE_BYTES:     exp_line_bytes = value[9:0];
      tpsc_pkg::CFG_BASE_ADDRESS:   exp_base_address = value[ADDR_W-1:0];
      default: begin
      end
    endcase
  endtask

  task automatic reconfigure(input int unsigned lines, input int unsigned total,
                             input int unsigned limit, input int unsigned bytes,
                             input int unsigned base);
    wait_for_idle();
    write_register(tpsc_pkg::CFG_SCROLLED_LINES, CFG_DATA_W'(lines));
    write_register(tpsc_pkg::CFG_TOTAL_LINES, CFG_DATA_W'(total));
    write_register(tpsc_pkg::CFG_TOP_LIMIT, CFG_DATA_W'(limit));
    write_register(tpsc_pkg::CFG_LINE_BYTES, CFG_DATA_W'(bytes));
    write_register(tpsc_pkg::CFG_BASE_ADDRESS, CFG_DATA_W'(base));
  endtask

  // runs of one direction with random line readiness, stops mixed in, some unused codes
  task automatic scroll_traffic(input int unsigned count);
    int unsigned sent;
    int unsigned run_len;
    int unsigned k;
    logic [1:0] dir;
    sent = 0;
    while (sent < count) begin
      dir = ($urandom_range(0, 1) != 0) ? tpsc_pkg::FUNC_DOWN : tpsc_pkg::FUNC_UP;
      run_len = $urandom_range(1, 20);
      for (k = 0; k < run_len && sent < count; k++) begin
        send_request(dir, $urandom_range(0, 3) != 0);
        sent++;
        if ($urandom_range(0, 4) == 0) begin
          send_request(tpsc_pkg::FUNC_STOP, $urandom_range(0, 1) != 0);
          sent++;
        end
      end
      if ($urandom_range(0, 9) == 0) send_request(FUNC_UNUSED, $urandom_range(0, 1) != 0);
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed_cases();
    in_gaps_on = 1'b1;
    out_stalls_on = 1'b1;
    send_request(tpsc_pkg::FUNC_STOP, 1'b0);     // stop while idle
    send_request(FUNC_UNUSED, 1'b1);
    send_request(FUNC_UNUSED, 1'b0);
    send_request(tpsc_pkg::FUNC_UP, 1'b0);       // scan zero steps to the next line
    send_request(tpsc_pkg::FUNC_UP, 1'b0);       // no line ready
    send_request(tpsc_pkg::FUNC_UP, 1'b1);
    send_request(tpsc_pkg::FUNC_DOWN, 1'b1);     // same top address again
    send_request(tpsc_pkg::FUNC_DOWN, 1'b1);     // write plus duplicate row
    send_request(tpsc_pkg::FUNC_DOWN, 1'b0);
    send_request(tpsc_pkg::FUNC_STOP, 1'b1);
    send_request(tpsc_pkg::FUNC_DOWN, 1'b0);     // no line ready
    send_request(tpsc_pkg::FUNC_DOWN, 1'b1);     // page swap down from row zero
    send_request(tpsc_pkg::FUNC_STOP, 1'b0);
    send_request(tpsc_pkg::FUNC_UP, 1'b0);
    send_request(tpsc_pkg::FUNC_STOP, 1'b0);
    send_request(tpsc_pkg::FUNC_UP, 1'b1);       // page swap up at the top limit
    send_request(tpsc_pkg::FUNC_STOP, 1'b0);
    send_request(tpsc_pkg::FUNC_STOP, 1'b0);
    send_request(tpsc_pkg::FUNC_UP, 1'b1);
    send_request(tpsc_pkg::FUNC_STOP, 1'b1);
    send_request(tpsc_pkg::FUNC_UP, 1'b1);       // write plus row two above
    send_request(tpsc_pkg::FUNC_STOP, 1'b0);
    send_request(tpsc_pkg::FUNC_DOWN, 1'b1);
  endtask

  task automatic test_min_config();
    reconfigure(1, 2, 1, 1, 0);
    in_gaps_on = 1'b0;
    out_stalls_on = 1'b1;
    scroll_traffic(60);
  endtask

  task automatic test_max_config();
    reconfigure(31, 63, 63, 1023, 131071);
    in_gaps_on = 1'b1;
    out_stalls_on = 1'b0;
    scroll_traffic(30);
    // hold off until every command of the first half is out
    wait_for_idle();
    scroll_traffic(30);
  endtask

  task automatic test_zero_top_limit();
    reconfigure(16, 34, 0, 144, 0);
    in_gaps_on = 1'b0;
    out_stalls_on = 1'b0;
    scroll_traffic(60);
  endtask

  task automatic test_address_wrap();
    reconfigure(5, 12, 3, 1023, 131071 - 100);
    in_gaps_on = 1'b1;
    out_stalls_on = 1'b1;
    scroll_traffic(60);
  endtask

  task automatic test_random_configs();
    int unsigned n;
    for (n = 0; n < 3; n++) begin
      reconfigure($urandom_range(1, 31), $urandom_range(2, 63),
                  (n == 0) ? $urandom_range(1, 63) : $urandom_range(1, 8),
                  $urandom_range(1, 1023), $urandom_range(0, 131071));
      in_gaps_on = (n != 1);
      out_stalls_on = (n != 2);
      scroll_traffic(70);
    end
  endtask

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin : check_cmds
    tpsc_pkg::res_t got;
    tpsc_pkg::res_t want;
    if (rst_n && out_valid && out_ready) begin
      got.command = out_command;
      got.row = out_row;
      got.scan = out_scan;
      got.halfword_address = out_halfword_address;
      got.address_changed = out_address_changed;
      got.last = out_last;
      if (expected_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected command: cmd=%0d row=%0d scan=%0d hw=%h chg=%0d last=%0d",
                   got.command, got.row, got.scan, got.halfword_address,
                   got.address_changed, got.last);
      end else begin
        want = expected_cmds.pop_front();
        if (got.command !== want.command || got.row !== want.row ||
            got.scan !== want.scan || got.halfword_address !== want.halfword_address ||
            got.address_changed !== want.address_changed || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("expected: cmd=%0d row=%0d scan=%0d hw=%h chg=%0d last=%0d",
                     want.command, want.row, want.scan, want.halfword_address,
                     want.address_changed, want.last);
            $display("actual:   cmd=%0d row=%0d scan=%0d hw=%h chg=%0d last=%0d",
                     got.command, got.row, got.scan, got.halfword_address,
                     got.address_changed, got.last);
          end
        end
      end
    end
  end

  // receiver back-pressure
  initial begin : drive_out_ready
    int unsigned stall;
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      stall = out_stalls_on ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = tpsc_pkg::FUNC_UP;
    in_line_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = tpsc_pkg::CFG_SCROLLED_LINES;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_cases();
    test_min_config();
    test_max_config();
    test_zero_top_limit();
    test_address_wrap();
    test_random_configs();

    wait_for_idle();
    repeat (6) @(posedge clk);
    if (mismatches == 0 && expected_cmds.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
